>>> sv/tgr_pkg.sv
// Shared types, codes and font table for the text glyph rasterizer.
`timescale 1ns / 1ps

package tgr_pkg;

    localparam int GLYPH_DEPTH = 136;

    localparam logic [7:0] CODE_NEWLINE = 8'd10;
    localparam logic [7:0] CODE_RETURN  = 8'd13;
    localparam logic [7:0] CODE_DAMAGED = 8'd124;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_SCALE     = 2'd0;
    localparam logic [1:0] REG_COLUMNS   = 2'd1;
    localparam logic [1:0] REG_FG_COLOUR = 2'd2;
    localparam logic [1:0] REG_BG_COLOUR = 2'd3;

    localparam logic [3:0]  RESET_SCALE     = 4'd1;
    localparam logic [7:0]  RESET_COLUMNS   = 8'd78;
    localparam logic [31:0] RESET_FG_COLOUR = 32'h0000_00FF;
    localparam logic [31:0] RESET_BG_COLOUR = 32'hFFFF_FF00;

    typedef struct packed {
        logic [3:0]  scale;
        logic [7:0]  columns;
        logic [31:0] fg_colour;
        logic [31:0] bg_colour;
    } tgr_cfg_t;

    // One glyph command handed from front to back
    typedef struct packed {
        logic [63:0] glyph;
        logic [15:0] ox;
        logic [15:0] oy;
    } tgr_cmd_t;

    function automatic logic [3:0] tgr_eff_scale(input logic [3:0] scale);
        logic [3:0] s;
        s = (scale == 4'd0) ? 4'd1 : scale;
        return s;
    endfunction

    // Font glyphs; the damaged entry is substituted by the caller
    function automatic logic [63:0] tgr_font_glyph(input logic [7:0] code);
        logic [63:0] g;
        case (code)
            8'd33:   g = 64'h183C3C1818001800;
            8'd34:   g = 64'h3636000000000000;
            8'd35:   g = 64'h36367F367F363600;
            8'd36:   g = 64'h0C3E031E301F0C00;
            8'd37:   g = 64'h006333180C666300;
            8'd38:   g = 64'h1C361C6E3B336E00;
            8'd39:   g = 64'h0606030000000000;
            8'd40:   g = 64'h180C0606060C1800;
            8'd41:   g = 64'h060C1818180C0600;
            8'd42:   g = 64'h00663CFF3C660000;
            8'd43:   g = 64'h000C0C3F0C0C0000;
            8'd44:   g = 64'h00000000000C0C06;
            8'd45:   g = 64'h0000003F00000000;
            8'd46:   g = 64'h00000000000C0C00;
            8'd47:   g = 64'h6030180C06030100;
            8'd48:   g = 64'h3E63737B6F673E00;
            8'd49:   g = 64'h0C0E0C0C0C0C3F00;
            8'd50:   g = 64'h1E33301C06333F00;
            8'd51:   g = 64'h1E33301C30331E00;
            8'd52:   g = 64'h383C36337F307800;
            8'd53:   g = 64'h3F031F3030331E00;
            8'd54:   g = 64'h1C06031F33331E00;
            8'd55:   g = 64'h3F3330180C0C0C00;
            8'd56:   g = 64'h1E33331E33331E00;
            8'd57:   g = 64'h1E33333E30180E00;
            8'd58:   g = 64'h000C0C00000C0C00;
            8'd59:   g = 64'h000C0C00000C0C06;
            8'd60:   g = 64'h180C0603060C1800;
            8'd61:   g = 64'h00003F00003F0000;
            8'd62:   g = 64'h060C1830180C0600;
            8'd63:   g = 64'h1E3330180C000C00;
            8'd64:   g = 64'h3E637B7B7B031E00;
            8'd65:   g = 64'h0C1E33333F333300;
            8'd66:   g = 64'h3F66663E66663F00;
            8'd67:   g = 64'h3C66030303663C00;
            8'd68:   g = 64'h1F36666666361F00;
            8'd69:   g = 64'h7F46161E16467F00;
            8'd70:   g = 64'h7F46161E16060F00;
            8'd71:   g = 64'h3C66030373667C00;
            8'd72:   g = 64'h3333333F33333300;
            8'd73:   g = 64'h1E0C0C0C0C0C1E00;
            8'd74:   g = 64'h7830303033331E00;
            8'd75:   g = 64'h6766361E36666700;
            8'd76:   g = 64'h0F06060646667F00;
            8'd77:   g = 64'h63777F7F6B636300;
            8'd78:   g = 64'h63676F7B73636300;
            8'd79:   g = 64'h1C36636363361C00;
            8'd80:   g = 64'h3F66663E06060F00;
            8'd81:   g = 64'h1E3333333B1E3800;
            8'd82:   g = 64'h3F66663E36666700;
            8'd83:   g = 64'h1E33070E38331E00;
            8'd84:   g = 64'h3F2D0C0C0C0C1E00;
            8'd85:   g = 64'h3333333333333F00;
            8'd86:   g = 64'h33333333331E0C00;
            8'd87:   g = 64'h6363636B7F776300;
            8'd88:   g = 64'h6363361C1C366300;
            8'd89:   g = 64'h3333331E0C0C1E00;
            8'd90:   g = 64'h7F6331184C667F00;
            8'd91:   g = 64'h1E06060606061E00;
            8'd92:   g = 64'h03060C1830604000;
            8'd93:   g = 64'h1E18181818181E00;
            8'd94:   g = 64'h081C366300000000;
            8'd95:   g = 64'h00000000000000FF;
            8'd96:   g = 64'h0C0C180000000000;
            8'd97:   g = 64'h00001E303E336E00;
            8'd98:   g = 64'h0706063E66663B00;
            8'd99:   g = 64'h00001E3303331E00;
            8'd100:  g = 64'h3830303E33336E00;
            8'd101:  g = 64'h00001E333F031E00;
            8'd102:  g = 64'h1C36060F06060F00;
            8'd103:  g = 64'h00006E33333E301F;
            8'd104:  g = 64'h0706366E66666700;
            8'd105:  g = 64'h0C000E0C0C0C1E00;
            8'd106:  g = 64'h300030303033331E;
            8'd107:  g = 64'h070666361E366700;
            8'd108:  g = 64'h0E0C0C0C0C0C1E00;
            8'd109:  g = 64'h0000337F7F6B6300;
            8'd110:  g = 64'h00001F3333333300;
            8'd111:  g = 64'h00001E3333331E00;
            8'd112:  g = 64'h00003B66663E060F;
            8'd113:  g = 64'h00006E33333E3078;
            8'd114:  g = 64'h00003B6E66060F00;
            8'd115:  g = 64'h00003E031E301F00;
            8'd116:  g = 64'h080C3E0C0C2C1800;
            8'd117:  g = 64'h0000333333336E00;
            8'd118:  g = 64'h00003333331E0C00;
            8'd119:  g = 64'h0000636B7F7F3600;
            8'd120:  g = 64'h000063361C366300;
            8'd121:  g = 64'h00003333333E301F;
            8'd122:  g = 64'h00003F190C263F00;
            8'd123:  g = 64'h380C0C070C0C3800;
            8'd125:  g = 64'h070C0C380C0C0700;
            8'd126:  g = 64'h6E3B000000000000;
            8'd128:  g = 64'h80C0E070371E1C08;
            8'd129:  g = 64'h00001C3E3E3E1C00;
            8'd130:  g = 64'h040C1C3C3C1C0C04;
            8'd131:  g = 64'h0000FF4224180000;
            8'd132:  g = 64'h7E7E7E7E7E7E3C18;
            8'd133:  g = 64'h0709FF81818181FF;
            8'd134:  g = 64'h784C46424242427E;
            8'd135:  g = 64'h183C7E1818181818;
            default: g = 64'h0;
        endcase
        return g;
    endfunction

endpackage

>>> sv/tgr_front.sv
// Front end: accepts characters, runs the text cursor, looks up glyphs.
`timescale 1ns / 1ps

module tgr_front #(
    parameter int          GLYPH_COUNT       = 136,
    parameter logic [63:0] DAMAGED_GLYPH_124 = 64'h0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tgr_pkg::tgr_cfg_t cfg,
    input  logic              push,
    output logic              full,
    input  logic              mode,
    input  logic [7:0]        char_code,
    input  logic [15:0]       pos_x,
    input  logic [15:0]       pos_y,
    output logic              cmd_push,
    output tgr_pkg::tgr_cmd_t cmd,
    input  logic              cmd_full
);
    import tgr_pkg::*;

    logic [7:0]  cursor_column_reg, cursor_column_next;
    logic [7:0]  cursor_row_reg, cursor_row_next;
    logic        accept;
    logic        is_control;
    logic [3:0]  s;
    logic [11:0] col_prod;
    logic [11:0] row_prod;
    logic [9:0]  col_plus3;
    logic        wrap;
    logic [63:0] glyph;

    assign full   = cmd_full;
    assign accept = push && !cmd_full;
    assign s      = tgr_eff_scale(cfg.scale);

    assign is_control = !mode && (char_code == CODE_NEWLINE || char_code == CODE_RETURN);

    assign col_prod = {4'd0, cursor_column_reg} * {8'd0, s};
    assign row_prod = {4'd0, cursor_row_reg} * {8'd0, s};

    // col + 1 > columns - 2, done unsigned as col + 3 > columns
    assign col_plus3 = {2'd0, cursor_column_reg} + 10'd3;
    assign wrap      = col_plus3 > {2'd0, cfg.columns};

    always_comb
    begin
        if ((9'(char_code) < 9'(GLYPH_COUNT)) && (9'(char_code) < 9'(GLYPH_DEPTH)))
        begin
            glyph = (char_code == CODE_DAMAGED) ? DAMAGED_GLYPH_124
                                                : tgr_font_glyph(char_code);
        end
        else
        begin
            glyph = 64'h0;
        end
    end

    always_comb
    begin
        cmd.glyph = glyph;
        if (mode)
        begin
            cmd.ox = pos_x;
            cmd.oy = pos_y;
        end
        else
        begin
            cmd.ox = {1'b0, col_prod, 3'd0};
            cmd.oy = {1'b0, row_prod, 3'd0};
        end
    end

    assign cmd_push = accept && !is_control;

    always_comb
    begin
        cursor_column_next = cursor_column_reg;
        cursor_row_next    = cursor_row_reg;
        if (accept && !mode)
        begin
            if (char_code == CODE_NEWLINE)
            begin
                cursor_column_next = 8'd0;
                cursor_row_next    = cursor_row_reg + 8'd1;
            end
            else if (char_code == CODE_RETURN)
            begin
                cursor_column_next = 8'd0;
            end
            else if (wrap)
            begin
                cursor_column_next = 8'd0;
                cursor_row_next    = cursor_row_reg + 8'd1;
            end
            else
            begin
                cursor_column_next = cursor_column_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_column_reg <= 8'd0;
            cursor_row_reg    <= 8'd0;
        end
        else
        begin
            cursor_column_reg <= cursor_column_next;
            cursor_row_reg    <= cursor_row_next;
        end
    end

endmodule

>>> sv/tgr_queue.sv
// Short command queue between front end and back end.
`timescale 1ns / 1ps

module tgr_queue #(
    parameter int DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  tgr_pkg::tgr_cmd_t wr_data,
    output logic              q_full,
    input  logic              rd_en,
    output tgr_pkg::tgr_cmd_t rd_data,
    output logic              q_valid
);
    import tgr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tgr_cmd_t           entries_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_wr;
    logic               do_rd;

    assign q_full  = (count_reg == CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign rd_data = entries_reg[rd_ptr_reg];

    assign do_wr = wr_en && !q_full;
    assign do_rd = rd_en && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entries_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> sv/tgr_back.sv
// Back end: walks 64 glyph bits, emitting one square per cycle while popped.
`timescale 1ns / 1ps

module tgr_back (
    input  logic              clk,
    input  logic              rst_n,
    input  tgr_pkg::tgr_cfg_t cfg,
    input  logic              q_valid,
    input  tgr_pkg::tgr_cmd_t q_data,
    output logic              q_pop,
    output logic              empty,
    input  logic              pop,
    output logic [15:0]       pixel_x,
    output logic [15:0]       pixel_y,
    output logic [31:0]       colour,
    output logic              last
);
    import tgr_pkg::*;

    logic        active_reg;
    logic [5:0]  bit_idx_reg;
    logic [63:0] glyph_reg;
    logic [15:0] ox_reg;
    logic [15:0] oy_reg;
    logic        out_valid_reg;
    logic [15:0] pixel_x_reg, pixel_x_next;
    logic [15:0] pixel_y_reg, pixel_y_next;
    logic [31:0] colour_reg, colour_next;
    logic        last_reg, last_next;

    logic        advance;
    logic        load;
    logic        final_bit;
    logic [3:0]  s;
    logic [2:0]  col;
    logic [2:0]  row;
    logic [6:0]  x_off;
    logic [7:0]  y_off;

    assign s   = tgr_eff_scale(cfg.scale);
    assign col = bit_idx_reg[2:0];
    assign row = bit_idx_reg[5:3];

    // output slot frees up when empty or taken this cycle
    assign advance   = active_reg && (!out_valid_reg || pop);
    assign final_bit = (bit_idx_reg == 6'd63);
    assign load      = q_valid && (!active_reg || (advance && final_bit));
    assign q_pop     = load;

    assign x_off = {4'd0, col} * {3'd0, s};
    assign y_off = (8'd8 - {5'd0, row}) * {4'd0, s};

    assign pixel_x_next = ox_reg + {9'd0, x_off};
    assign pixel_y_next = oy_reg + {8'd0, y_off};
    assign colour_next  = glyph_reg[bit_idx_reg] ? cfg.fg_colour : cfg.bg_colour;
    assign last_next    = final_bit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            bit_idx_reg   <= 6'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end

            if (load)
            begin
                active_reg  <= 1'b1;
                bit_idx_reg <= 6'd0;
            end
            else
            begin
                if (advance && final_bit)
                begin
                    active_reg <= 1'b0;
                end
                if (advance)
                begin
                    bit_idx_reg <= bit_idx_reg + 6'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            glyph_reg <= q_data.glyph;
            ox_reg    <= q_data.ox;
            oy_reg    <= q_data.oy;
        end
        if (advance)
        begin
            pixel_x_reg <= pixel_x_next;
            pixel_y_reg <= pixel_y_next;
            colour_reg  <= colour_next;
            last_reg    <= last_next;
        end
    end

    assign empty   = !out_valid_reg;
    assign pixel_x = pixel_x_reg;
    assign pixel_y = pixel_y_reg;
    assign colour  = colour_reg;
    assign last    = last_reg;

endmodule

>>> sv/text_glyph_rasterizer_unit.sv
// Top level of the text glyph rasterizer: config registers, front end, queue, back end.
// A pushed command is queued, loaded by the back end, and its first square is then registered.
// Each drawn character gives 64 squares, one square per cycle while the receiver pops;
// newline and carriage return in cursor mode give no squares.
// The front end keeps accepting until the command queue (QUEUE_DEPTH entries) fills.
// Reset: rst_n async low; cursor at 0,0, registers at defaults, queue and output empty.
`timescale 1ns / 1ps

module text_glyph_rasterizer_unit #(
    parameter int          GLYPH_COUNT       = 136,
    parameter logic [63:0] DAMAGED_GLYPH_124 = 64'h0,
    parameter int          QUEUE_DEPTH       = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  logic        mode,
    input  logic [7:0]  char_code,
    input  logic [15:0] pos_x,
    input  logic [15:0] pos_y,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] pixel_x,
    output logic [15:0] pixel_y,
    output logic [31:0] colour,
    output logic        last
);
    import tgr_pkg::*;

    logic [3:0]  scale_reg;
    logic [7:0]  columns_reg;
    logic [31:0] fg_colour_reg;
    logic [31:0] bg_colour_reg;
    logic        cfg_wr;
    logic [1:0]  reg_idx;
    tgr_cfg_t    cfg;

    logic        cmd_push;
    tgr_cmd_t    cmd;
    logic        cmd_full;
    logic        q_pop;
    tgr_cmd_t    q_data;
    logic        q_valid;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg     <= RESET_SCALE;
            columns_reg   <= RESET_COLUMNS;
            fg_colour_reg <= RESET_FG_COLOUR;
            bg_colour_reg <= RESET_BG_COLOUR;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_SCALE:     scale_reg     <= pwdata[3:0];
                REG_COLUMNS:   columns_reg   <= pwdata[7:0];
                REG_FG_COLOUR: fg_colour_reg <= pwdata;
                REG_BG_COLOUR: bg_colour_reg <= pwdata;
                default:       scale_reg     <= scale_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_SCALE:     prdata = {28'd0, scale_reg};
            REG_COLUMNS:   prdata = {24'd0, columns_reg};
            REG_FG_COLOUR: prdata = fg_colour_reg;
            REG_BG_COLOUR: prdata = bg_colour_reg;
            default:       prdata = 32'd0;
        endcase
    end

    assign cfg.scale     = scale_reg;
    assign cfg.columns   = columns_reg;
    assign cfg.fg_colour = fg_colour_reg;
    assign cfg.bg_colour = bg_colour_reg;

    tgr_front #(
        .GLYPH_COUNT       (GLYPH_COUNT),
        .DAMAGED_GLYPH_124 (DAMAGED_GLYPH_124)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .push      (push),
        .full      (full),
        .mode      (mode),
        .char_code (char_code),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .cmd_push  (cmd_push),
        .cmd       (cmd),
        .cmd_full  (cmd_full)
    );

    tgr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd),
        .q_full  (cmd_full),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .q_valid (q_valid)
    );

    tgr_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .pixel_x (pixel_x),
        .pixel_y (pixel_y),
        .colour  (colour),
        .last    (last)
    );

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the text glyph rasterizer unit.
`timescale 1ns / 1ps

module testbench;

    import tgr_pkg::*;

    localparam int          GLYPHS      = 136;
    localparam logic [63:0] DAMAGED     = 64'h0;
    localparam logic        MODE_CURSOR = 1'b0;
    localparam logic        MODE_AT     = 1'b1;
    localparam int          SETTLE      = 16;
    localparam int          HOLD_CYCLES = 400;
    localparam int          GLYPH_COUNT_TB = 136;

    localparam logic [63:0] FONT_ROM [136] = '{
        64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0,
        64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0,
        64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0,
        64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0,
        64'h0000000000000000, 64'h183C3C1818001800, 64'h3636000000000000, 64'h36367F367F363600,
        64'h0C3E031E301F0C00, 64'h006333180C666300, 64'h1C361C6E3B336E00, 64'h0606030000000000,
        64'h180C0606060C1800, 64'h060C1818180C0600, 64'h00663CFF3C660000, 64'h000C0C3F0C0C0000,
        64'h00000000000C0C06, 64'h0000003F00000000, 64'h00000000000C0C00, 64'h6030180C06030100,
        64'h3E63737B6F673E00, 64'h0C0E0C0C0C0C3F00, 64'h1E33301C06333F00, 64'h1E33301C30331E00,
        64'h383C36337F307800, 64'h3F031F3030331E00, 64'h1C06031F33331E00, 64'h3F3330180C0C0C00,
        64'h1E33331E33331E00, 64'h1E33333E30180E00, 64'h000C0C00000C0C00, 64'h000C0C00000C0C06,
        64'h180C0603060C1800, 64'h00003F00003F0000, 64'h060C1830180C0600, 64'h1E3330180C000C00,
        64'h3E637B7B7B031E00, 64'h0C1E33333F333300, 64'h3F66663E66663F00, 64'h3C66030303663C00,
        64'h1F36666666361F00, 64'h7F46161E16467F00, 64'h7F46161E16060F00, 64'h3C66030373667C00,
        64'h3333333F33333300, 64'h1E0C0C0C0C0C1E00, 64'h7830303033331E00, 64'h6766361E36666700,
        64'h0F06060646667F00, 64'h63777F7F6B636300, 64'h63676F7B73636300, 64'h1C36636363361C00,
        64'h3F66663E06060F00, 64'h1E3333333B1E3800, 64'h3F66663E36666700, 64'h1E33070E38331E00,
        64'h3F2D0C0C0C0C1E00, 64'h3333333333333F00, 64'h33333333331E0C00, 64'h6363636B7F776300,
        64'h6363361C1C366300, 64'h3333331E0C0C1E00, 64'h7F6331184C667F00, 64'h1E06060606061E00,
        64'h03060C1830604000, 64'h1E18181818181E00, 64'h081C366300000000, 64'h00000000000000FF,
        64'h0C0C180000000000, 64'h00001E303E336E00, 64'h0706063E66663B00, 64'h00001E3303331E00,
        64'h3830303E33336E00, 64'h00001E333F031E00, 64'h1C36060F06060F00, 64'h00006E33333E301F,
        64'h0706366E66666700, 64'h0C000E0C0C0C1E00, 64'h300030303033331E, 64'h070666361E366700,
        64'h0E0C0C0C0C0C1E00, 64'h0000337F7F6B6300, 64'h00001F3333333300, 64'h00001E3333331E00,
        64'h00003B66663E060F, 64'h00006E33333E3078, 64'h00003B6E66060F00, 64'h00003E031E301F00,
        64'h080C3E0C0C2C1800, 64'h0000333333336E00, 64'h00003333331E0C00, 64'h0000636B7F7F3600,
        64'h000063361C366300, 64'h00003333333E301F, 64'h00003F190C263F00, 64'h380C0C070C0C3800,
        DAMAGED,              64'h070C0C380C0C0700, 64'h6E3B000000000000, 64'h0000000000000000,
        64'h80C0E070371E1C08, 64'h00001C3E3E3E1C00, 64'h040C1C3C3C1C0C04, 64'h0000FF4224180000,
        64'h7E7E7E7E7E7E3C18, 64'h0709FF81818181FF, 64'h784C46424242427E, 64'h183C7E1818181818
    };

    typedef struct {
        logic [15:0] px;
        logic [15:0] py;
        logic [31:0] colour;
        logic        last;
    } square_t;

    class glyph_scoreboard;
        logic [3:0]  scale;
        logic [7:0]  columns;
        logic [31:0] fg;
        logic [31:0] bg;
        logic [7:0]  col;
        logic [7:0]  row;
        square_t     squares [$];
        int          errors;

        function new();
            scale   = RESET_SCALE;
            columns = RESET_COLUMNS;
            fg      = RESET_FG_COLOUR;
            bg      = RESET_BG_COLOUR;
            col     = 8'd0;
            row     = 8'd0;
            errors  = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_SCALE:     scale   = value[3:0];
                REG_COLUMNS:   columns = value[7:0];
                REG_FG_COLOUR: fg      = value;
                REG_BG_COLOUR: bg      = value;
                default: ;
            endcase
        endfunction

        function int pending();
            return squares.size();
        endfunction

        function int eff_scale();
            return (scale == 4'd0) ? 1 : int'(scale);
        endfunction

        // 64 squares, LSB first; glyph row r lands at oy + (8 - r) * s
        function void draw_glyph(logic [7:0] code, logic [15:0] ox, logic [15:0] oy);
            logic [63:0] g;
            square_t     sq;
            int          s;
            s = eff_scale();
            g = (int'(code) < GLYPH_COUNT_TB && int'(code) < GLYPHS) ? FONT_ROM[code] : 64'h0;
            for (int k = 0; k < 64; k++)
            begin
                sq.px     = 16'(int'(ox) + (k % 8) * s);
                sq.py     = 16'(int'(oy) + (8 - k / 8) * s);
                sq.colour = g[k] ? fg : bg;
                sq.last   = (k == 63);
                squares.push_back(sq);
            end
        endfunction

        function void note_char(logic m, logic [7:0] code, logic [15:0] x, logic [15:0] y);
            int s;
            s = eff_scale();
            if (m == MODE_AT)
                draw_glyph(code, x, y);
            else if (code == CODE_NEWLINE)
            begin
                col = 8'd0;
                row = row + 8'd1;
            end
            else if (code == CODE_RETURN)
                col = 8'd0;
            else
            begin
                draw_glyph(code, 16'(int'(col) * 8 * s), 16'(int'(row) * 8 * s));
                // signed compare: columns below two always wrap
                if (int'(col) + 1 > int'(columns) - 2)
                begin
                    col = 8'd0;
                    row = row + 8'd1;
                end
                else
                    col = col + 8'd1;
            end
        endfunction

        function void cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v)
            begin
                $error("square field %s: expected %h, got %h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_square(logic [15:0] px, logic [15:0] py, logic [31:0] c, logic l);
            square_t sq;
            if (squares.size() == 0)
            begin
                $error("square at %h,%h with no transaction outstanding", px, py);
                errors++;
                return;
            end
            sq = squares.pop_front();
            cmp_field("pixel_x", 32'(sq.px), 32'(px));
            cmp_field("pixel_y", 32'(sq.py), 32'(py));
            cmp_field("colour", sq.colour, c);
            cmp_field("last", 32'(sq.last), 32'(l));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        push;
    logic        full;
    logic        mode;
    logic [7:0]  char_code;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic        empty;
    logic        pop;
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic [31:0] colour;
    logic        last;

    glyph_scoreboard sb = new();
    int hold_token = 0;

    text_glyph_rasterizer_unit #(
        .GLYPH_COUNT       (GLYPH_COUNT_TB),
        .DAMAGED_GLYPH_124 (DAMAGED)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .push      (push),
        .full      (full),
        .mode      (mode),
        .char_code (char_code),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .empty     (empty),
        .pop       (pop),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .colour    (colour),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Transaction monitors
    always @(posedge clk)
    begin
        if (rst_n && push && !full)
            sb.note_char(mode, char_code, pos_x, pos_y);
        if (rst_n && pop && !empty)
            sb.check_square(pixel_x, pixel_y, colour, last);
    end

    // Receiver: random stall windows plus an occasional long hold-off
    initial
    begin
        int stall_pct;
        int win_left;
        int hold_left;
        int hold_seen;
        stall_pct = 0;
        win_left  = 0;
        hold_left = 0;
        hold_seen = 0;
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_token != hold_seen)
            begin
                hold_seen = hold_token;
                hold_left = HOLD_CYCLES;
            end
            if (win_left == 0)
            begin
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 15;
                    2: stall_pct = 40;
                    default: stall_pct = 60;
                endcase
                win_left = $urandom_range(50, 300);
            end
            win_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                pop = 1'b0;
            end
            else
                pop = ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic send_char(logic m, logic [7:0] code, logic [15:0] x, logic [15:0] y);
        mode      = m;
        char_code = code;
        pos_x     = x;
        pos_y     = y;
        push      = 1'b1;
        do @(posedge clk); while (full);
        @(negedge clk);
    endtask

    task automatic drain();
        push = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_reg(idx, value);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Only while idle; drain first, then settle before the register writes
    task automatic configure(logic [3:0] s, logic [7:0] cols, logic [31:0] fg, logic [31:0] bg);
        drain();
        repeat (SETTLE) @(negedge clk);
        write_reg(REG_SCALE, 32'(s));
        write_reg(REG_COLUMNS, 32'(cols));
        write_reg(REG_FG_COLOUR, fg);
        write_reg(REG_BG_COLOUR, bg);
    endtask

    function automatic logic [31:0] pick_colour();
        case ($urandom_range(0, 2))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int       burst;
        int       nl_run;
        int       sel;
        logic     m;
        logic [7:0] code;
        logic [3:0] s;
        logic [7:0] cols;

        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = 4'd0;
        pwdata    = 32'd0;
        push      = 1'b0;
        mode      = MODE_CURSOR;
        char_code = 8'd0;
        pos_x     = 16'd0;
        pos_y     = 16'd0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: reset settings, controls, blank and damaged codes, edge origins
        send_char(MODE_CURSOR, "H", 16'd0, 16'd0);
        send_char(MODE_CURSOR, "i", 16'd0, 16'd0);
        send_char(MODE_CURSOR, CODE_NEWLINE, 16'd0, 16'd0);
        send_char(MODE_CURSOR, "A", 16'd0, 16'd0);
        send_char(MODE_CURSOR, CODE_RETURN, 16'd0, 16'd0);
        send_char(MODE_CURSOR, "!", 16'd0, 16'd0);
        send_char(MODE_CURSOR, 8'd0, 16'd0, 16'd0);
        send_char(MODE_CURSOR, 8'd255, 16'hFFFF, 16'hFFFF);
        send_char(MODE_AT, "A", 16'd0, 16'd0);
        send_char(MODE_AT, CODE_NEWLINE, 16'd100, 16'd200);
        send_char(MODE_AT, CODE_RETURN, 16'hFFFF, 16'hFFFF);
        send_char(MODE_AT, CODE_DAMAGED, 16'h5555, 16'hAAAA);
        send_char(MODE_AT, 8'd135, 16'hAAAA, 16'h5555);
        send_char(MODE_AT, 8'd136, 16'd8, 16'd8);
        send_char(MODE_AT, 8'd127, 16'hFFF8, 16'h0003);
        push = 1'b0;

        // scale zero acts as one; wide lines move the cursor far right
        configure(4'd0, 8'd255, 32'hFFFF_FFFF, 32'h0);
        repeat (6) send_char(MODE_CURSOR, "W", 16'd0, 16'd0);
        push = 1'b0;

        // cursor already past the new threshold wraps at once
        configure(4'd15, 8'd4, 32'h0, 32'hFFFF_FFFF);
        send_char(MODE_CURSOR, "Z", 16'd0, 16'd0);
        send_char(MODE_CURSOR, "a", 16'd0, 16'd0);
        push = 1'b0;

        // columns below two: every character wraps
        configure(4'd8, 8'd0, 32'h1234_5678, 32'h8765_4321);
        send_char(MODE_CURSOR, "#", 16'd0, 16'd0);
        send_char(MODE_CURSOR, "$", 16'd0, 16'd0);
        push = 1'b0;

        // Random phases
        nl_run = 0;
        for (int ph = 0; ph < 8; ph++)
        begin
            case ($urandom_range(0, 4))
                0: s = 4'd0;
                1: s = 4'd1;
                2: s = 4'd8;
                3: s = 4'd15;
                default: s = 4'($urandom_range(1, 8));
            endcase
            case ($urandom_range(0, 6))
                0: cols = 8'd0;
                1: cols = 8'd1;
                2: cols = 8'd2;
                3: cols = 8'd3;
                4: cols = 8'd255;
                5: cols = RESET_COLUMNS;
                default: cols = 8'($urandom_range(2, 255));
            endcase
            configure(s, cols, pick_colour(), pick_colour());

            if (ph == 2)
            begin
                // receiver holds off while the sender keeps pushing: input must stall
                hold_token++;
                repeat (12) send_char(MODE_CURSOR, 8'($urandom_range(32, 126)), 16'd0, 16'd0);
                push = 1'b0;
            end

            burst = $urandom_range(1, 16);
            for (int i = 0; i < 62; i++)
            begin
                if (nl_run == 0 && $urandom_range(0, 39) == 0)
                    nl_run = $urandom_range(20, 60);
                if (nl_run > 0)
                begin
                    nl_run--;
                    m    = MODE_CURSOR;
                    code = CODE_NEWLINE;
                end
                else if ($urandom_range(0, 3) == 0)
                begin
                    m    = MODE_AT;
                    code = 8'($urandom_range(0, 255));
                end
                else
                begin
                    m   = MODE_CURSOR;
                    sel = $urandom_range(0, 99);
                    if (sel < 12)
                        code = CODE_NEWLINE;
                    else if (sel < 17)
                        code = CODE_RETURN;
                    else if (sel < 27)
                        code = 8'($urandom_range(0, 255));
                    else
                        code = 8'($urandom_range(32, 135));
                end
                send_char(m, code, 16'($urandom), 16'($urandom));
                burst--;
                if (burst == 0)
                begin
                    push = 1'b0;
                    repeat ($urandom_range(0, 20)) @(negedge clk);
                    if ($urandom_range(0, 7) == 0)
                        drain();
                    burst = $urandom_range(1, 16);
                end
            end
            push = 1'b0;
        end

        drain();
        repeat (SETTLE) @(negedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
